FILE: rtl/nfsa_pkg.sv
package nfsa_pkg;

    // table geometry
    localparam int NUM_SLOTS = 4096;
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int STEP_W    = $clog2(NUM_WORDS + 1);
    localparam int SLOT_W    = WORD_AW + BIT_W;

    // bits of the last map word that hold real slots
    localparam int TAIL_BITS = NUM_SLOTS - (NUM_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_WORD_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - TAIL_BITS);

    // field widths
    localparam int CMD_W = 2;
    localparam int IDX_W = 12;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] slot_to_free;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] slot_index;
        logic             status;
    } out_word_t;

    typedef struct packed {
        logic                 wr_en;
        logic [WORD_AW-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic [WORD_AW-1:0]   rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } free_hit_t;

endpackage

FILE: rtl/nfsa_map_ram.sv
module nfsa_map_ram (
    input  logic                                 aclk,
    input  nfsa_pkg::ram_req_t                   req,
    output logic [nfsa_pkg::WORD_BITS-1:0]       rd_data
);

    logic [nfsa_pkg::WORD_BITS-1:0] mem [nfsa_pkg::NUM_WORDS];
    logic [nfsa_pkg::WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/nfsa_find_free.sv
module nfsa_find_free (
    input  logic [nfsa_pkg::WORD_BITS-1:0] cand,
    output nfsa_pkg::free_hit_t            hit
);

    // lowest set bit wins
    always_comb begin
        hit = '0;
        for (int i = nfsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit.found   = 1'b1;
                hit.bit_idx = nfsa_pkg::BIT_W'(i);
            end
        end
    end

endmodule

FILE: rtl/next_fit_slot_allocator.sv
// Allocate: the result waits on the one-word-per-cycle walk through the map RAM
//   read port, which can visit every map word and then revisit the start word.
// Free: read-modify-write of one map word. Clear, unused cmd: straight to the result.
// One word in flight; s_ready returns as the result is registered, along with m_valid.
// aresetn (sync, active low): per-row valid bits drop at once, so the whole map
//   reads free straight after reset with no clearing pass; scan start goes to 1.
module next_fit_slot_allocator (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  nfsa_pkg::in_word_t   s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output nfsa_pkg::out_word_t  m_word
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    localparam int WB  = nfsa_pkg::WORD_BITS;
    localparam int WAW = nfsa_pkg::WORD_AW;
    localparam int BW  = nfsa_pkg::BIT_W;
    localparam int SW  = nfsa_pkg::STEP_W;

    logic [1:0]                  state_reg, state_next;
    logic [WAW-1:0]              scan_word_reg, scan_word_next;
    logic [BW-1:0]               scan_bit_reg, scan_bit_next;
    logic [nfsa_pkg::NUM_WORDS-1:0] map_valid_reg, map_valid_next;
    logic [SW-1:0]               eval_step_reg, eval_step_next;
    logic [WAW-1:0]              eval_word_reg, eval_word_next;
    logic [WAW-1:0]              issue_word_reg, issue_word_next;
    logic [WAW-1:0]              victim_word_reg, victim_word_next;
    logic [BW-1:0]               victim_bit_reg, victim_bit_next;
    logic [nfsa_pkg::IDX_W-1:0]  res_slot_reg, res_slot_next;
    logic                        res_status_reg, res_status_next;
    logic                        m_valid_reg, m_valid_next;
    nfsa_pkg::out_word_t         m_word_reg, m_word_next;

    nfsa_pkg::ram_req_t          ram_req;
    logic [WB-1:0]               ram_q;
    logic [WAW-1:0]              cur_word;
    logic [WB-1:0]               cur_data;
    logic [WB-1:0]               head_mask;
    logic [WB-1:0]               scan_mask;
    logic [WB-1:0]               cand;
    nfsa_pkg::free_hit_t         hit;
    logic [nfsa_pkg::SLOT_W-1:0] found_slot;
    logic [WAW-1:0]              in_victim_word;
    logic                        in_victim_ok;

    function automatic logic [WAW-1:0] next_word(input logic [WAW-1:0] w);
        next_word = (w == WAW'(nfsa_pkg::NUM_WORDS - 1)) ? '0 : w + 1'b1;
    endfunction

    nfsa_map_ram u_map (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_q)
    );

    nfsa_find_free u_find (
        .cand (cand),
        .hit  (hit)
    );

    // decode of the incoming free target
    assign in_victim_word = WAW'(s_word.slot_to_free >> BW);
    assign in_victim_ok   = 32'(s_word.slot_to_free) < nfsa_pkg::NUM_SLOTS;

    // word under test; a row never written since reset or clear reads all free
    assign cur_word = (state_reg == ST_FREE) ? victim_word_reg : eval_word_reg;
    assign cur_data = map_valid_reg[cur_word] ? ram_q : '0;

    // first visit of the start word covers bits from the start bit up,
    // the closing revisit covers the bits below it
    assign head_mask = {WB{1'b1}} << scan_bit_reg;

    always_comb begin
        if (eval_step_reg == '0) begin
            scan_mask = head_mask;
        end else if (eval_step_reg == SW'(nfsa_pkg::NUM_WORDS)) begin
            scan_mask = ~head_mask;
        end else begin
            scan_mask = {WB{1'b1}};
        end
        if (eval_word_reg == WAW'(nfsa_pkg::NUM_WORDS - 1)) begin
            scan_mask = scan_mask & nfsa_pkg::LAST_WORD_MASK;
        end
    end

    assign cand       = ~cur_data & scan_mask;
    assign found_slot = {eval_word_reg, hit.bit_idx};

    always_comb begin
        state_next       = state_reg;
        scan_word_next   = scan_word_reg;
        scan_bit_next    = scan_bit_reg;
        map_valid_next   = map_valid_reg;
        eval_step_next   = eval_step_reg;
        eval_word_next   = eval_word_reg;
        issue_word_next  = issue_word_reg;
        victim_word_next = victim_word_reg;
        victim_bit_next  = victim_bit_reg;
        res_slot_next    = res_slot_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg;
        m_word_next      = m_word_reg;

        ram_req          = '0;
        ram_req.rd_addr  = issue_word_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // read is issued in the accept cycle
                if (s_word.cmd == nfsa_pkg::CMD_FREE) begin
                    ram_req.rd_addr = in_victim_word;
                end else begin
                    ram_req.rd_addr = scan_word_reg;
                end
                if (s_valid) begin
                    res_slot_next   = '0;
                    res_status_next = nfsa_pkg::STATUS_OK;
                    state_next      = ST_RESP;
                    unique case (s_word.cmd)
                        nfsa_pkg::CMD_ALLOC: begin
                            eval_step_next  = '0;
                            eval_word_next  = scan_word_reg;
                            issue_word_next = next_word(scan_word_reg);
                            state_next      = ST_SCAN;
                        end
                        nfsa_pkg::CMD_FREE: begin
                            scan_word_next = '0;
                            scan_bit_next  = '0;
                            if (in_victim_ok) begin
                                victim_word_next = in_victim_word;
                                victim_bit_next  = s_word.slot_to_free[BW-1:0];
                                state_next       = ST_FREE;
                            end
                        end
                        nfsa_pkg::CMD_CLEAR: begin
                            map_valid_next = '0;
                            scan_word_next = '0;
                            scan_bit_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // one map word tested per cycle while the next is being read
                if (hit.found) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = eval_word_reg;
                    ram_req.wr_data = cur_data | (WB'(1) << hit.bit_idx);
                    map_valid_next[eval_word_reg] = 1'b1;
                    res_slot_next   = nfsa_pkg::IDX_W'(found_slot);
                    if (hit.bit_idx == BW'(WB - 1)) begin
                        scan_word_next = next_word(eval_word_reg);
                        scan_bit_next  = '0;
                    end else if (found_slot ==
                                 nfsa_pkg::SLOT_W'(nfsa_pkg::NUM_SLOTS - 1)) begin
                        scan_word_next = '0;
                        scan_bit_next  = '0;
                    end else begin
                        scan_word_next = eval_word_reg;
                        scan_bit_next  = hit.bit_idx + 1'b1;
                    end
                    state_next = ST_RESP;
                end else if (eval_step_reg == SW'(nfsa_pkg::NUM_WORDS)) begin
                    // wrapped back to the start: table full, state untouched
                    res_status_next = nfsa_pkg::STATUS_FULL;
                    state_next      = ST_RESP;
                end else begin
                    eval_step_next  = eval_step_reg + 1'b1;
                    eval_word_next  = next_word(eval_word_reg);
                    issue_word_next = next_word(issue_word_reg);
                end
            end

            ST_FREE: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = victim_word_reg;
                ram_req.wr_data = cur_data & ~(WB'(1) << victim_bit_reg);
                map_valid_next[victim_word_reg] = 1'b1;
                state_next = ST_RESP;
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_word_next.slot_index = res_slot_reg;
                    m_word_next.status     = res_status_reg;
                    state_next             = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_word_reg <= '0;
            scan_bit_reg  <= BW'(1);
            map_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_word_reg <= scan_word_next;
            scan_bit_reg  <= scan_bit_next;
            map_valid_reg <= map_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        eval_step_reg   <= eval_step_next;
        eval_word_reg   <= eval_word_next;
        issue_word_reg  <= issue_word_next;
        victim_word_reg <= victim_word_next;
        victim_bit_reg  <= victim_bit_next;
        res_slot_reg    <= res_slot_next;
        res_status_reg  <= res_status_next;
        m_word_reg      <= m_word_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

FILE: rtl/nfsa_checker.sv
module nfsa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input nfsa_pkg::in_word_t  s_word,
    input logic                m_valid,
    input logic                m_ready,
    input nfsa_pkg::out_word_t m_word
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // a failed allocate carries no slot
    a_full_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word.status == nfsa_pkg::STATUS_FULL) |-> m_word.slot_index == '0)
        else $error("full status with non-zero slot");

    // one word at a time: busy straight after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after accept");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind next_fit_slot_allocator nfsa_checker u_nfsa_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // cmd value with no meaning: the block must answer it with a plain done word
    localparam logic [nfsa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int IDX_MAX     = (1 << nfsa_pkg::IDX_W) - 1;
    localparam int LONG_HOLD   = 300;       // receiver hold-off, in cycles
    localparam int TAIL_CYCLES = 100;       // longer than the worst allocate
    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_REPORTS = 10;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    nfsa_pkg::in_word_t  s_word  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    nfsa_pkg::out_word_t m_word;

    next_fit_slot_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow allocator: one used bit per slot plus the next-fit pointer.
    // Updated at the edge where a request word is accepted, so the
    // expected grants come out in acceptance order.
    // ------------------------------------------------------------------
    logic [nfsa_pkg::NUM_SLOTS-1:0] taken_map;
    int                             scan_pos;

    nfsa_pkg::in_word_t  request_q[$];       // words waiting to be offered
    nfsa_pkg::out_word_t pending_grants[$];  // predicted answers, oldest first

    int  mismatch_count = 0;
    int  cycles_run     = 0;
    logic in_taken      = 1'b0;   // request word accepted at the last rising edge
    logic out_taken     = 1'b0;   // answer word taken at the last rising edge
    bit  steady         = 1'b0;   // suppresses idling on both sides
    int  long_holds_asked = 0;
    int  long_holds_done  = 0;
    int  tx_left = 0;
    int  rx_left = 0;

    // Works out the answer to one request and moves the shadow state on.
    function automatic nfsa_pkg::out_word_t grant_for_request(nfsa_pkg::in_word_t req);
        nfsa_pkg::out_word_t grant;
        int        pos;
        int        i;
        bit        found;
        grant = '0;
        case (req.cmd)
            nfsa_pkg::CMD_ALLOC: begin
                pos   = (scan_pos >= nfsa_pkg::NUM_SLOTS) ? 0 : scan_pos;
                found = 1'b0;
                // circular walk, each slot visited at most once
                for (i = 0; i < nfsa_pkg::NUM_SLOTS && !found; i++) begin
                    if (!taken_map[pos])
                        found = 1'b1;
                    else
                        pos = (pos == nfsa_pkg::NUM_SLOTS - 1) ? 0 : pos + 1;
                end
                if (found) begin
                    taken_map[pos]   = 1'b1;
                    scan_pos         = (pos == nfsa_pkg::NUM_SLOTS - 1) ? 0 : pos + 1;
                    grant.slot_index = pos[nfsa_pkg::IDX_W-1:0];
                    grant.status     = nfsa_pkg::STATUS_OK;
                end else begin
                    // table full: nothing moves
                    grant.status = nfsa_pkg::STATUS_FULL;
                end
            end
            nfsa_pkg::CMD_FREE: begin
                // out-of-range index leaves the map alone but still rewinds
                if (req.slot_to_free < nfsa_pkg::NUM_SLOTS)
                    taken_map[req.slot_to_free] = 1'b0;
                scan_pos = 0;
            end
            nfsa_pkg::CMD_CLEAR: begin
                taken_map = '0;
                scan_pos  = 0;
            end
            default: begin
                // unused command: no effect, plain done
            end
        endcase
        return grant;
    endfunction

    function automatic void report_mismatch(string what, nfsa_pkg::out_word_t want,
                                            nfsa_pkg::out_word_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: slot_index want %0d got %0d, status want %0d got %0d",
                     $time, what, want.slot_index, got.slot_index, want.status, got.status);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge, runs the shadow
    // model for each accepted request and checks each answer word.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        nfsa_pkg::out_word_t want;
        in_taken  <= aresetn && s_valid && s_ready;
        out_taken <= aresetn && m_valid && m_ready;
        if (!aresetn) begin
            taken_map = '0;
            scan_pos  = 1 % nfsa_pkg::NUM_SLOTS;
        end else begin
            if (s_valid && s_ready)
                pending_grants.push_back(grant_for_request(s_word));
            if (m_valid && m_ready) begin
                if (pending_grants.size() == 0) begin
                    report_mismatch("unexpected word", '0, m_word);
                end else begin
                    want = pending_grants.pop_front();
                    if (m_word.slot_index !== want.slot_index ||
                        m_word.status !== want.status)
                        report_mismatch("wrong word", want, m_word);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. A word, once offered,
    // is held until accepted; a fresh word may follow at once.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (in_taken)
                tx_left = pick_gap();
            if (tx_left > 0) begin
                s_valid <= 1'b0;
                tx_left = tx_left - 1;
            end else if (request_q.size() != 0) begin
                s_word  <= request_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure after each word, plus the long
    // hold-offs asked for by the sequence below.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (out_taken)
                rx_left = pick_gap();
            if (long_holds_done != long_holds_asked) begin
                rx_left = LONG_HOLD;
                long_holds_done = long_holds_done + 1;
            end
            if (rx_left > 0) begin
                m_ready <= 1'b0;
                rx_left = rx_left - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    // keep at most two words queued so picks see a near-current map
    task automatic offer(input logic [nfsa_pkg::CMD_W-1:0] cmd,
                         input logic [nfsa_pkg::IDX_W-1:0] slot);
        nfsa_pkg::in_word_t w;
        while (request_q.size() >= 2)
            @(negedge aclk);
        w.cmd          = cmd;
        w.slot_to_free = slot;
        request_q.push_back(w);
    endtask

    // any slot index the field can carry
    function automatic logic [nfsa_pkg::IDX_W-1:0] rand_idx();
        int unsigned r;
        r = $urandom_range(0, IDX_MAX);
        return r[nfsa_pkg::IDX_W-1:0];
    endfunction

    // a slot that is held now, if one turns up within a few tries
    function automatic logic [nfsa_pkg::IDX_W-1:0] pick_taken_slot();
        int s;
        int tries;
        s     = $urandom_range(0, nfsa_pkg::NUM_SLOTS - 1);
        tries = 0;
        while (!taken_map[s] && tries < 64) begin
            s = $urandom_range(0, nfsa_pkg::NUM_SLOTS - 1);
            tries++;
        end
        return s[nfsa_pkg::IDX_W-1:0];
    endfunction

    // weights in percent; whatever is left over goes to clear
    task automatic offer_random_request(input int alloc_w, input int free_w,
                                        input int stray_w, input int noop_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < alloc_w)
            offer(nfsa_pkg::CMD_ALLOC, rand_idx());
        else if (r < alloc_w + free_w)
            offer(nfsa_pkg::CMD_FREE, pick_taken_slot());
        else if (r < alloc_w + free_w + stray_w)
            offer(nfsa_pkg::CMD_FREE, rand_idx());   // often an idle slot
        else if (r < alloc_w + free_w + stray_w + noop_w)
            offer(CMD_UNUSED, rand_idx());
        else
            offer(nfsa_pkg::CMD_CLEAR, rand_idx());
    endtask

    // sender stops until every predicted answer has been seen
    task automatic drain_all();
        while (request_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (pending_grants.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int n;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fill from reset: pointer starts at 1, so grants run 1, 2, 3 ...
        // and slot 0 stays idle. First part unthrottled.
        steady = 1'b1;
        for (n = 0; n < 320; n++) begin
            if (n == 150)
                steady = 1'b0;
            offer(nfsa_pkg::CMD_ALLOC, rand_idx());
        end

        // Directed edge cases on a part-filled table
        offer(CMD_UNUSED,          12'hFFF);
        offer(nfsa_pkg::CMD_FREE,  12'hFFF);   // idle top slot; still rewinds
        offer(nfsa_pkg::CMD_ALLOC, 12'h000);   // slot 0
        offer(nfsa_pkg::CMD_ALLOC, 12'hFFF);   // walks past the filled run
        offer(nfsa_pkg::CMD_FREE,  12'h000);
        offer(nfsa_pkg::CMD_FREE,  12'h000);   // freeing an idle slot
        offer(nfsa_pkg::CMD_ALLOC, 12'h000);
        offer(nfsa_pkg::CMD_FREE,  12'h055);
        offer(nfsa_pkg::CMD_FREE,  12'h0AA);
        offer(nfsa_pkg::CMD_ALLOC, 12'h000);
        offer(nfsa_pkg::CMD_ALLOC, 12'h000);
        offer(nfsa_pkg::CMD_ALLOC, 12'h000);   // past the run again
        offer(nfsa_pkg::CMD_FREE,  12'h800);
        offer(nfsa_pkg::CMD_ALLOC, 12'hFFF);
        offer(CMD_UNUSED,          12'h000);
        offer(nfsa_pkg::CMD_FREE,  12'h13F);   // top bit of a map row
        offer(nfsa_pkg::CMD_ALLOC, 12'hFFF);
        drain_all();

        // Churn: walks from slot 0 after each free over the used run.
        // One long receiver hold-off while the sender keeps offering.
        for (n = 0; n < 250; n++) begin
            if (n == 60)
                long_holds_asked = long_holds_asked + 1;
            if (n == 150)
                drain_all();
            offer_random_request(50, 35, 8, 6);
        end
        drain_all();

        // Clear, then a sparse table with the odd clear thrown in
        offer(nfsa_pkg::CMD_CLEAR, 12'hFFF);
        offer(nfsa_pkg::CMD_ALLOC, 12'h000);
        offer(nfsa_pkg::CMD_ALLOC, 12'h000);
        offer(nfsa_pkg::CMD_FREE,  12'h001);
        offer(nfsa_pkg::CMD_ALLOC, 12'h000);
        for (n = 0; n < 210; n++) begin
            if (n == 80)
                long_holds_asked = long_holds_asked + 1;
            steady = (n >= 100 && n < 140);
            offer_random_request(58, 22, 8, 6);
        end
        steady = 1'b0;

        drain_all();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_grants.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
